// ===== design/rrts_pkg.sv =====
// Package with the shared types and constants of the round-robin time-slice scheduler.
package rrts_pkg;

    localparam logic REQ_ENTER = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    localparam logic [7:0]  SLICE_RESET = 8'd2;
    localparam logic [7:0]  SLICE_MAX   = 8'hFF;
    localparam logic [15:0] RAN_MAX     = 16'hFFFF;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  proc_id;
        logic [15:0] need_time;
    } item_t;

    typedef struct packed {
        logic [7:0] running_id;
        logic       running_valid;
        logic [7:0] finished_id;
        logic       finished_valid;
        logic       all_done;
        logic       enter_dropped;
    } result_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] need;
        logic [15:0] ran;
    } proc_entry_t;

    typedef struct packed {
        logic        push;
        logic        pop;
        proc_entry_t push_entry;
    } queue_ctl_t;

    typedef struct packed {
        logic empty;
        logic one_left;
        logic full_idle;
        logic full_run;
    } queue_stat_t;

endpackage

// ===== design/rrts_queue.sv =====
// Ready queue of the scheduler: entry memory, pointers, count and a prefetched head entry.
module rrts_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rrts_pkg::queue_ctl_t ctl,
    output rrts_pkg::queue_stat_t stat,
    output rrts_pkg::proc_entry_t head_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rrts_pkg::proc_entry_t mem [QUEUE_DEPTH];
    rrts_pkg::proc_entry_t head_data_reg;

    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] result;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            result = '0;
        end else begin
            result = ptr + 1'b1;
        end
        return result;
    endfunction

    always_comb
    begin
        head_next  = ctl.pop ? step_ptr(head_reg) : head_reg;
        tail_next  = ctl.push ? step_ptr(tail_reg) : tail_reg;
        count_next = count_reg;
        if (ctl.push && !ctl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (ctl.pop && !ctl.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push) begin
            mem[tail_reg] <= ctl.push_entry;
        end
    end

    // The head entry is prefetched into a register from the next head slot; a write into that slot is forwarded.
    always_ff @(posedge clk)
    begin
        if (ctl.push && (tail_reg == head_next)) begin
            head_data_reg <= ctl.push_entry;
        end else begin
            head_data_reg <= mem[head_next];
        end
    end

    assign head_entry     = head_data_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.one_left  = (count_reg == CNT_W'(1));
    assign stat.full_idle = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign stat.full_run  = (count_reg >= CNT_W'(QUEUE_DEPTH - 1));

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.push && !ctl.pop && stat.full_idle))
        else $error("push into a full ready queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.pop && stat.empty))
        else $error("pop from an empty ready queue");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.push && !ctl.pop) |=> !stat.empty)
        else $error("queue empty right after a push");

endmodule

// ===== design/round_robin_time_slice_scheduler_core.sv =====
// Top level of the round-robin time-slice scheduler: input register, scheduling step, result register.
//
// The block accepts one transaction in every clock cycle (busy is always low). It raises done and
// presents the result at the edge after the accepting edge, for one cycle, and the receiver has
// no way to stall the result. An enter transaction appends a process to the ready queue unless
// it is full (the running process counts), when it is dropped; a tick transaction dispatches the
// queue head when no process runs and advances the running process, finishing or requeueing it.
// All the work for one transaction is done in the cycle between the input register and the result
// register, with the ready queue memory supplying a prefetched head entry. The time slice register
// is to be written through cfg_valid/cfg_ready while no transaction is in flight; the block does not enforce it.
module round_robin_time_slice_scheduler_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rrts_pkg::item_t   item,
    output logic              done,
    output rrts_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data
);

    rrts_pkg::item_t       item_reg;
    logic                  item_valid_reg;
    logic [7:0]            time_slice_reg;

    rrts_pkg::proc_entry_t cur_reg;
    rrts_pkg::proc_entry_t cur_next;
    logic [7:0]            slice_reg;
    logic [7:0]            slice_next;
    logic                  running_reg;
    logic                  running_next;

    rrts_pkg::result_t     result_reg;
    rrts_pkg::result_t     result_next;
    logic                  done_reg;

    rrts_pkg::queue_ctl_t  qctl;
    rrts_pkg::queue_stat_t qstat;
    rrts_pkg::proc_entry_t head_entry;

    rrts_pkg::proc_entry_t act;
    logic                  is_tick;
    logic                  dispatch;
    logic                  act_running;
    logic [7:0]            act_slice;
    logic [7:0]            slice_inc;
    logic [15:0]           ran_inc;
    logic [7:0]            limit;
    logic                  finish;
    logic                  requeue;
    logic                  dropped;
    logic                  enter_ok;
    logic [15:0]           need_fixed;
    logic                  queue_empty_after;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            time_slice_reg <= rrts_pkg::SLICE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            time_slice_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy) begin
            item_reg <= item;
        end
    end

    always_comb
    begin
        is_tick     = item_valid_reg && (item_reg.req_type == rrts_pkg::REQ_TICK);
        dispatch    = is_tick && !running_reg && !qstat.empty;
        act_running = running_reg || dispatch;
        act         = dispatch ? head_entry : cur_reg;
        act_slice   = dispatch ? 8'd0 : slice_reg;
        limit       = (time_slice_reg == 8'd0) ? 8'd1 : time_slice_reg;
        ran_inc     = (act.ran == rrts_pkg::RAN_MAX) ? act.ran : act.ran + 16'd1;
        slice_inc   = (act_slice == rrts_pkg::SLICE_MAX) ? act_slice : act_slice + 8'd1;
        finish      = is_tick && act_running && (ran_inc >= act.need);
        requeue     = is_tick && act_running && !finish && (slice_inc >= limit);

        dropped     = item_valid_reg && (item_reg.req_type == rrts_pkg::REQ_ENTER)
                      && (running_reg ? qstat.full_run : qstat.full_idle);
        enter_ok    = item_valid_reg && (item_reg.req_type == rrts_pkg::REQ_ENTER) && !dropped;
        need_fixed  = (item_reg.need_time == 16'd0) ? 16'd1 : item_reg.need_time;

        qctl.pop  = dispatch;
        qctl.push = enter_ok || requeue;
        if (requeue) begin
            qctl.push_entry.id   = act.id;
            qctl.push_entry.need = act.need;
            qctl.push_entry.ran  = ran_inc;
        end else begin
            qctl.push_entry.id   = item_reg.proc_id;
            qctl.push_entry.need = need_fixed;
            qctl.push_entry.ran  = 16'd0;
        end

        cur_next     = cur_reg;
        slice_next   = slice_reg;
        running_next = running_reg;
        if (is_tick && act_running) begin
            cur_next.id   = act.id;
            cur_next.need = act.need;
            cur_next.ran  = ran_inc;
            slice_next    = (finish || requeue) ? 8'd0 : slice_inc;
            running_next  = !(finish || requeue);
        end

        queue_empty_after = (qstat.empty && !qctl.push)
                            || (qstat.one_left && qctl.pop && !qctl.push);

        result_next.running_id     = running_next ? cur_next.id : 8'd0;
        result_next.running_valid  = running_next;
        result_next.finished_id    = finish ? act.id : 8'd0;
        result_next.finished_valid = finish;
        result_next.all_done       = queue_empty_after && !running_next;
        result_next.enter_dropped  = dropped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_reg     <= '0;
            slice_reg   <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            cur_reg     <= cur_next;
            slice_reg   <= slice_next;
            running_reg <= running_next;
            done_reg    <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    rrts_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (qctl),
        .stat       (qstat),
        .head_entry (head_entry)
    );

    a_state_only_on_item: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |=> (running_reg == $past(running_reg)))
        else $error("running state changed without a transaction");

    a_finish_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.finished_valid)
        |-> $past(item_valid_reg && (item_reg.req_type == rrts_pkg::REQ_TICK)))
        else $error("finish reported for a transaction that was not a tick");

    a_done_excludes_running: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.all_done && result.running_valid))
        else $error("all_done reported while a process runs");

endmodule

// ===== verif/tb_round_robin_time_slice_scheduler_core.sv =====
// Self-checking testbench for the round-robin time-slice scheduler core.
`timescale 1ns / 100ps

module tb_round_robin_time_slice_scheduler_core;

    localparam int QUEUE_DEPTH = 16;
    localparam int SETTLE_CYCLES = 6;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    rrts_pkg::item_t       item = '0;
    logic                  done;
    rrts_pkg::result_t     result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [7:0]            cfg_data = 8'd0;

    rrts_pkg::item_t       pending_items[$];
    rrts_pkg::result_t     expected_results[$];
    int                    error_count = 0;
    int                    burst_left = 0;
    int                    gap_left = 0;

    rrts_pkg::proc_entry_t waiting_procs[$];
    rrts_pkg::proc_entry_t running_proc = '0;
    logic                  proc_running = 1'b0;
    logic [7:0]            slice_count = 8'd0;
    logic [7:0]            slice_setting = rrts_pkg::SLICE_RESET;

    round_robin_time_slice_scheduler_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    function automatic rrts_pkg::result_t predict_schedule_step(rrts_pkg::item_t it);
        rrts_pkg::result_t r;
        logic [15:0]       need;
        logic [7:0]        limit;
        r = '0;
        if (it.req_type == rrts_pkg::REQ_ENTER) begin
            if (waiting_procs.size() + (proc_running ? 1 : 0) >= QUEUE_DEPTH) begin
                r.enter_dropped = 1'b1;
            end
            else begin
                need = (it.need_time == 16'd0) ? 16'd1 : it.need_time;
                waiting_procs.push_back('{id: it.proc_id, need: need, ran: 16'd0});
            end
        end
        else begin
            if (!proc_running && waiting_procs.size() > 0) begin
                running_proc = waiting_procs.pop_front();
                slice_count = 8'd0;
                proc_running = 1'b1;
            end
            if (proc_running) begin
                limit = (slice_setting == 8'd0) ? 8'd1 : slice_setting;
                if (running_proc.ran != rrts_pkg::RAN_MAX) begin
                    running_proc.ran = running_proc.ran + 16'd1;
                end
                if (slice_count != rrts_pkg::SLICE_MAX) begin
                    slice_count = slice_count + 8'd1;
                end
                if (running_proc.ran >= running_proc.need) begin
                    r.finished_id = running_proc.id;
                    r.finished_valid = 1'b1;
                    proc_running = 1'b0;
                    slice_count = 8'd0;
                end
                else if (slice_count >= limit) begin
                    waiting_procs.push_back(running_proc);
                    proc_running = 1'b0;
                    slice_count = 8'd0;
                end
            end
        end
        r.running_valid = proc_running;
        r.running_id = proc_running ? running_proc.id : 8'd0;
        r.all_done = (waiting_procs.size() == 0) && !proc_running;
        return r;
    endfunction

    function automatic rrts_pkg::item_t random_item();
        rrts_pkg::item_t it;
        int unsigned     pick;
        it.req_type = ($urandom_range(0, 99) < 58) ? rrts_pkg::REQ_TICK : rrts_pkg::REQ_ENTER;
        it.proc_id = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            it.need_time = 16'($urandom_range(0, 65535));
        end
        else if (pick < 5) begin
            it.need_time = 16'd0;
        end
        else if (pick < 15) begin
            it.need_time = 16'($urandom_range(1, 40));
        end
        else begin
            it.need_time = 16'($urandom_range(1, 6));
        end
        return it;
    endfunction

    task automatic add_enter(logic [7:0] id, logic [15:0] need);
        pending_items.push_back('{req_type: rrts_pkg::REQ_ENTER, proc_id: id, need_time: need});
    endtask

    task automatic add_tick();
        pending_items.push_back('{req_type: rrts_pkg::REQ_TICK, proc_id: 8'd0, need_time: 16'd0});
    endtask

    task automatic add_random_items(int count);
        @(negedge clk);
        for (int i = 0; i < count; i++) begin
            pending_items.push_back(random_item());
        end
    endtask

    task automatic wait_until_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_time_slice(logic [7:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do begin
            @(posedge clk);
        end while (!(cfg_valid && cfg_ready));
        slice_setting = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, exp_val,
                act_val);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy) begin
                expected_results.push_back(predict_schedule_step(item));
                void'(pending_items.pop_front());
            end
            if (!(start && busy)) begin
                if (gap_left != 0) begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    start <= 1'b1;
                    item <= pending_items[0];
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                              : $urandom_range(0, 3);
                    end
                    else begin
                        burst_left--;
                    end
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin
        rrts_pkg::result_t exp_res;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual %h", $time, result);
                error_count++;
            end
            else begin
                exp_res = expected_results.pop_front();
                check_field("running_id", 32'(exp_res.running_id), 32'(result.running_id));
                check_field("running_valid", 32'(exp_res.running_valid),
                    32'(result.running_valid));
                check_field("finished_id", 32'(exp_res.finished_id), 32'(result.finished_id));
                check_field("finished_valid", 32'(exp_res.finished_valid),
                    32'(result.finished_valid));
                check_field("all_done", 32'(exp_res.all_done), 32'(result.all_done));
                check_field("enter_dropped", 32'(exp_res.enter_dropped),
                    32'(result.enter_dropped));
            end
        end
    end

    initial begin
        logic [7:0] slice_plan[5];
        slice_plan[0] = 8'd1;
        slice_plan[1] = 8'd255;
        slice_plan[2] = 8'd0;
        slice_plan[3] = 8'd3;
        slice_plan[4] = 8'($urandom_range(1, 255));

        add_tick();
        add_enter(8'h00, 16'h0000);
        add_enter(8'hFF, 16'hFFFF);
        add_enter(8'h5A, 16'd3);
        add_tick();
        add_tick();
        add_tick();
        for (int i = 0; i < 15; i++) begin
            add_enter(8'h10 + i[7:0], 16'd1 + i[15:0] % 16'd3);
        end
        add_tick();
        add_tick();
        add_tick();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_random_items(55);
        for (int p = 0; p < 5; p++) begin
            wait_until_drained();
            write_time_slice(slice_plan[p]);
            add_random_items(75);
        end
        wait_until_drained();

        if (error_count == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/rrts_pkg.sv
design/rrts_queue.sv
design/round_robin_time_slice_scheduler_core.sv
verif/tb_round_robin_time_slice_scheduler_core.sv
